/* rtl/ommc_pkg.sv */
`timescale 1ns / 1ps
package ommc_pkg;

	// default maximum vector length and dims register reset value
	localparam int MAX_DIMS_DEF = 8;
	localparam logic [3:0] DIMS_RESET = 4'd4;

	// function codes of the trigger beat
	localparam logic [2:0] FN_ADD        = 3'd0;
	localparam logic [2:0] FN_REMOVE     = 3'd1;
	localparam logic [2:0] FN_ADD_VAR    = 3'd2;
	localparam logic [2:0] FN_REMOVE_VAR = 3'd3;
	localparam logic [2:0] FN_CLEAR      = 3'd4;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_SETUP,
		OP_DIV_START,
		OP_DIV_TAKE,
		OP_DIFF,
		OP_COV_RD,
		OP_MUL,
		OP_FIN,
		OP_COV_WR,
		OP_CLEAR,
		OP_COUNT,
		OP_EMIT_MEAN,
		OP_EMIT_COV
	} ommc_op_t;

	// multiplier operand pairs, in the order one covariance element uses them
	typedef enum logic [1:0] {
		MS_DD,
		MS_CV,
		MS_PR,
		MS_VAR
	} ommc_msel_t;

	// divider jobs
	typedef enum logic [1:0] {
		DS_P1,
		DS_P2,
		DS_QV,
		DS_MEAN
	} ommc_dsel_t;

	typedef struct packed {
		ommc_op_t   op;
		ommc_msel_t msel;
		ommc_dsel_t dsel;
		logic [1:0] step;
		logic [2:0] row;
		logic [2:0] col;
		logic       rem;
		logic       last;
		logic       buf_wr;
	} ommc_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
		logic count_le1;
	} ommc_sts_t;

endpackage

/* rtl/online_mean_covariance_unit.sv */
`timescale 1ns / 1ps
// Items that do not complete a vector are taken one per cycle while the unit is idle.
// A completing update is paced by a 64-step serial divider and one shared 32x32
// multiplier, whose work grows with D active dims and with variance; clear and
// small-count remove go straight to emitting results. Means then leave one per cycle
// while the output is not stalled, then D*(D+1)/2 covariances, each read first.
// Asynchronous active-low reset clears count, mean and covariance and sets dims to 4.
module online_mean_covariance_unit #(
	parameter int MAX_DIMS = ommc_pkg::MAX_DIMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [3:0]         cfg_write_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic [2:0]         component,
	input  logic signed [31:0] value,
	input  logic [62:0]        variance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic [2:0]         row,
	output logic [2:0]         col,
	output logic signed [63:0] result_value,
	output logic [31:0]        sample_count,
	output logic               last
);
	import ommc_pkg::*;

	ommc_cmd_t cmd;
	ommc_sts_t sts;

	ommc_ctrl #(.MAX_DIMS(MAX_DIMS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.component      (component),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.sts            (sts),
		.cmd            (cmd)
	);

	ommc_dp #(.MAX_DIMS(MAX_DIMS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.component    (component),
		.value        (value),
		.variance     (variance),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.row          (row),
		.col          (col),
		.result_value (result_value),
		.sample_count (sample_count),
		.last         (last)
	);
endmodule

/* rtl/ommc_ram.sv */
`timescale 1ns / 1ps
module ommc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 36
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/ommc_ctrl.sv */
`timescale 1ns / 1ps
module ommc_ctrl #(
	parameter int MAX_DIMS = ommc_pkg::MAX_DIMS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          func,
	input  logic [2:0]          component,
	input  logic                cfg_write_en,
	input  logic [3:0]          cfg_write_data,
	input  ommc_pkg::ommc_sts_t sts,
	output ommc_pkg::ommc_cmd_t cmd
);
	import ommc_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'h001,
		S_SETUP = 12'h002,
		S_DIVS  = 12'h004,
		S_DIVW  = 12'h008,
		S_DIFF  = 12'h010,
		S_CRD   = 12'h020,
		S_CMUL  = 12'h040,
		S_CWR   = 12'h080,
		S_COUNT = 12'h100,
		S_EMM   = 12'h200,
		S_ERD   = 12'h400,
		S_ECOV  = 12'h800
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] dims_q, dims_eff;
	logic [2:0] dl;
	logic       rem_q, rem_d, var_q, var_d;
	ommc_dsel_t dsel_q, dsel_d;
	ommc_msel_t ph_q, ph_d;
	logic [2:0] r_q, r_d, c_q, c_d, sub_q, sub_d;
	logic [2:0] r_nx, c_nx;
	logic       in_acc, trig, tri_end;

	// effective vector length
	always_comb begin
		if (dims_q == 4'd0) begin
			dims_eff = 4'd1;
		end else if (dims_q > 4'(MAX_DIMS)) begin
			dims_eff = 4'(MAX_DIMS);
		end else begin
			dims_eff = dims_q;
		end
	end
	assign dl = 3'(dims_eff - 4'd1);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign trig     = in_acc && (component == dl);

	// next upper-triangle position
	assign tri_end = (r_q == dl) && (c_q == dl);
	always_comb begin
		if (c_q == dl) begin
			r_nx = r_q + 3'd1;
			c_nx = r_q + 3'd1;
		end else begin
			r_nx = r_q;
			c_nx = c_q + 3'd1;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		var_d   = var_q;
		dsel_d  = dsel_q;
		ph_d    = ph_q;
		r_d     = r_q;
		c_d     = c_q;
		sub_d   = sub_q;
		cmd        = '0;
		cmd.op     = OP_NOP;
		cmd.msel   = ph_q;
		cmd.dsel   = dsel_q;
		cmd.step   = sub_q[1:0];
		cmd.row    = r_q;
		cmd.col    = c_q;
		cmd.rem    = rem_q;
		cmd.buf_wr = in_acc;
		case (state_q)
			S_IDLE: begin
				r_d = 3'd0;
				c_d = 3'd0;
				if (trig) begin
					case (func)
						FN_ADD, FN_REMOVE, FN_ADD_VAR, FN_REMOVE_VAR: begin
							rem_d = func[0];
							var_d = func[1];
							if (func[0] && sts.count_le1) begin
								cmd.op  = OP_CLEAR;
								state_d = S_EMM;
							end else begin
								state_d = S_SETUP;
							end
						end
						FN_CLEAR: begin
							cmd.op  = OP_CLEAR;
							state_d = S_EMM;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SETUP: begin
				cmd.op  = OP_SETUP;
				dsel_d  = DS_P1;
				state_d = S_DIVS;
			end
			S_DIVS: begin
				cmd.op  = OP_DIV_START;
				state_d = S_DIVW;
			end
			S_DIVW: begin
				if (!sts.div_busy) begin
					cmd.op = OP_DIV_TAKE;
					case (dsel_q)
						DS_P1: begin
							dsel_d  = DS_P2;
							state_d = S_DIVS;
						end
						DS_P2: begin
							dsel_d  = DS_QV;
							state_d = S_DIVS;
						end
						DS_QV: begin
							state_d = S_DIFF;
						end
						default: begin
							if (r_q == dl) begin
								state_d = S_COUNT;
							end else begin
								r_d     = r_q + 3'd1;
								state_d = S_DIVS;
							end
						end
					endcase
				end
			end
			S_DIFF: begin
				cmd.op  = OP_DIFF;
				r_d     = 3'd0;
				c_d     = 3'd0;
				state_d = S_CRD;
			end
			S_CRD: begin
				cmd.op  = OP_COV_RD;
				ph_d    = MS_DD;
				sub_d   = 3'd0;
				state_d = S_CMUL;
			end
			S_CMUL: begin
				// four partial products, a drain step, then the finishing step
				if (sub_q < 3'd4) begin
					cmd.op = OP_MUL;
					sub_d  = sub_q + 3'd1;
				end else if (sub_q == 3'd4) begin
					sub_d = 3'd5;
				end else begin
					cmd.op = OP_FIN;
					sub_d  = 3'd0;
					case (ph_q)
						MS_DD: ph_d = MS_CV;
						MS_CV: ph_d = MS_PR;
						MS_PR: begin
							if (var_q && (r_q == c_q)) begin
								ph_d = MS_VAR;
							end else begin
								state_d = S_CWR;
							end
						end
						default: state_d = S_CWR;
					endcase
				end
			end
			S_CWR: begin
				cmd.op = OP_COV_WR;
				if (tri_end) begin
					r_d     = 3'd0;
					dsel_d  = DS_MEAN;
					state_d = S_DIVS;
				end else begin
					r_d     = r_nx;
					c_d     = c_nx;
					state_d = S_CRD;
				end
			end
			S_COUNT: begin
				cmd.op  = OP_COUNT;
				r_d     = 3'd0;
				state_d = S_EMM;
			end
			S_EMM: begin
				if (sts.out_free) begin
					cmd.op = OP_EMIT_MEAN;
					if (r_q == dl) begin
						r_d     = 3'd0;
						c_d     = 3'd0;
						state_d = S_ERD;
					end else begin
						r_d = r_q + 3'd1;
					end
				end
			end
			S_ERD: begin
				cmd.op  = OP_COV_RD;
				state_d = S_ECOV;
			end
			S_ECOV: begin
				if (sts.out_free) begin
					cmd.op   = OP_EMIT_COV;
					cmd.last = tri_end;
					if (tri_end) begin
						state_d = S_IDLE;
					end else begin
						r_d     = r_nx;
						c_d     = c_nx;
						state_d = S_ERD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dims_q  <= DIMS_RESET;
			rem_q   <= 1'b0;
			var_q   <= 1'b0;
			dsel_q  <= DS_P1;
			ph_q    <= MS_DD;
			r_q     <= 3'd0;
			c_q     <= 3'd0;
			sub_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
			var_q   <= var_d;
			dsel_q  <= dsel_d;
			ph_q    <= ph_d;
			r_q     <= r_d;
			c_q     <= c_d;
			sub_q   <= sub_d;
			if (cfg_write_en) begin
				dims_q <= cfg_write_data;
			end
		end
	end
endmodule

/* rtl/ommc_dp.sv */
`timescale 1ns / 1ps
module ommc_dp #(
	parameter int MAX_DIMS = ommc_pkg::MAX_DIMS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ommc_pkg::ommc_cmd_t cmd,
	output ommc_pkg::ommc_sts_t sts,
	input  logic [2:0]          component,
	input  logic signed [31:0]  value,
	input  logic [62:0]         variance,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                kind,
	output logic [2:0]          row,
	output logic [2:0]          col,
	output logic signed [63:0]  result_value,
	output logic [31:0]         sample_count,
	output logic                last
);
	import ommc_pkg::*;

	localparam int RW       = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
	localparam int COV_SIZE = MAX_DIMS * (MAX_DIMS + 1) / 2;
	localparam int CW       = COV_SIZE > 1 ? $clog2(COV_SIZE) : 1;
	localparam int AW       = 99;
	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};

	// triangle position of (r, c), row-major
	function automatic logic [CW-1:0] tri_idx(input logic [2:0] r, input logic [2:0] c);
		int t;
		t = int'(r) * MAX_DIMS - (int'(r) * (int'(r) - 1)) / 2 + int'(c) - int'(r);
		return CW'(t);
	endfunction

	function automatic logic [31:0] mag_d(input logic signed [32:0] d);
		logic [32:0] t;
		t = d[32] ? (33'd0 - d) : d;
		return t[31:0];
	endfunction

	// sign * round(acc / 2^32), saturated
	function automatic logic signed [63:0] scale_res(input logic neg, input logic [AW-1:0] a);
		logic [AW-1:0] f;
		logic [63:0]   m;
		f = a + AW'(32'h8000_0000);
		m = f[95:32];
		if (|f[AW-1:96]) begin
			return neg ? S64_MIN : S64_MAX;
		end
		if (!neg) begin
			return m[63] ? S64_MAX : signed'(m);
		end
		if (m[63]) begin
			return S64_MIN;
		end
		return -signed'(m);
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
	                                                input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	logic signed [31:0] point_q [MAX_DIMS];
	logic [62:0]        var_q   [MAX_DIMS];
	logic signed [31:0] mean_q  [MAX_DIMS];
	logic signed [32:0] d_q     [MAX_DIMS];
	logic [31:0]        count_q;
	logic [32:0]        den_q, den_n;
	logic [31:0]        half_q;
	logic [33:0]        p1_q, p2_q;
	logic [32:0]        qv_q;
	logic [63:0]        dvd_q, quo_q, dvd_n;
	logic [32:0]        rem_q;
	logic [33:0]        rem_sh, rem_n;
	logic               rem_ge;
	logic [6:0]         dcnt_q;
	logic               busy_q;
	logic [63:0]        a_op, b_op, pp_s1;
	logic [31:0]        a_part, b_part;
	logic               mv_s1, first_s1;
	logic [1:0]         step_s1;
	logic [AW-1:0]      acc_q, pp_sh;
	logic [63:0]        prod_q;
	logic signed [63:0] t_q, cv, sc;
	logic [63:0]        cv_mag;
	logic               neg;
	logic [COV_SIZE-1:0] vld_q;
	logic               rvld_q;
	logic [63:0]        rdata;
	logic [CW-1:0]      cidx;
	logic [RW-1:0]      ri, ci;
	logic signed [34:0] nm, step_v;
	logic signed [31:0] nm_sat;

	assign ri   = cmd.row[RW-1:0];
	assign ci   = cmd.col[RW-1:0];
	assign cidx = tri_idx(cmd.row, cmd.col);

	// covariance store; entries never written since a clear read as zero
	ommc_ram #(.WIDTH(64), .DEPTH(COV_SIZE)) u_cov (
		.clk   (clk),
		.we    (cmd.op == OP_COV_WR),
		.waddr (cidx),
		.wdata (t_q),
		.re    (cmd.op == OP_COV_RD),
		.raddr (cidx),
		.rdata (rdata)
	);
	assign cv     = rvld_q ? signed'(rdata) : 64'sd0;
	assign cv_mag = cv[63] ? (64'd0 - cv) : cv;

	assign sts.div_busy  = busy_q;
	assign sts.out_free  = !out_valid || !out_stall;
	assign sts.count_le1 = (count_q <= 32'd1);

	// operand pair and partial product slice
	always_comb begin
		case (cmd.msel)
			MS_DD: begin
				a_op = {32'd0, mag_d(d_q[ri])};
				b_op = {32'd0, mag_d(d_q[ci])};
			end
			MS_CV: begin
				a_op = cv_mag;
				b_op = 64'(p1_q);
			end
			MS_PR: begin
				a_op = prod_q;
				b_op = 64'(p2_q);
			end
			default: begin
				a_op = {1'b0, var_q[ri]};
				b_op = 64'(qv_q);
			end
		endcase
		a_part = cmd.step[1] ? a_op[63:32] : a_op[31:0];
		b_part = cmd.step[0] ? b_op[63:32] : b_op[31:0];
	end

	always_comb begin
		case (step_s1)
			2'b00:   pp_sh = AW'(pp_s1);
			2'b11:   pp_sh = AW'(pp_s1) << 64;
			default: pp_sh = AW'(pp_s1) << 32;
		endcase
	end

	// sign of the finished term
	always_comb begin
		case (cmd.msel)
			MS_CV:   neg = cv[63];
			MS_PR:   neg = d_q[ri][32] ^ d_q[ci][32] ^ cmd.rem;
			MS_VAR:  neg = cmd.rem;
			default: neg = 1'b0;
		endcase
		sc = scale_res(neg, acc_q);
	end

	// divider step and dividend choice
	always_comb begin
		rem_sh = {rem_q, dvd_q[63]};
		rem_ge = (rem_sh >= {1'b0, den_q});
		rem_n  = rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
		case (cmd.dsel)
			DS_P1:   dvd_n = {count_q, half_q};
			DS_P2:   dvd_n = 64'(p1_q) + 64'(half_q);
			DS_QV:   dvd_n = 64'h1_0000_0000 + 64'(half_q);
			default: dvd_n = 64'(mag_d(d_q[ri])) + 64'(half_q);
		endcase
		den_n = cmd.rem ? (33'(count_q) - 33'd1) : (33'(count_q) + 33'd1);
	end

	// mean update with saturation
	always_comb begin
		step_v = signed'({1'b0, quo_q[33:0]});
		if (d_q[ri][32] ^ cmd.rem) begin
			nm = 35'(mean_q[ri]) - step_v;
		end else begin
			nm = 35'(mean_q[ri]) + step_v;
		end
		if (!nm[34] && (|nm[33:31])) begin
			nm_sat = 32'sh7FFF_FFFF;
		end else if (nm[34] && !(&nm[33:31])) begin
			nm_sat = 32'sh8000_0000;
		end else begin
			nm_sat = nm[31:0];
		end
	end

	// statistics, divider and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 32'd0;
			vld_q     <= '0;
			busy_q    <= 1'b0;
			dcnt_q    <= 7'd0;
			mv_s1     <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				mean_q[i] <= 32'sd0;
			end
		end else begin
			mv_s1 <= (cmd.op == OP_MUL);
			if (cmd.op == OP_DIV_START) begin
				busy_q <= 1'b1;
				dcnt_q <= 7'd64;
			end else if (busy_q) begin
				dcnt_q <= dcnt_q - 7'd1;
				if (dcnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
			case (cmd.op)
				OP_CLEAR: begin
					count_q <= 32'd0;
					vld_q   <= '0;
					for (int i = 0; i < MAX_DIMS; i++) begin
						mean_q[i] <= 32'sd0;
					end
				end
				OP_COV_WR: begin
					vld_q[cidx] <= 1'b1;
				end
				OP_DIV_TAKE: begin
					if (cmd.dsel == DS_MEAN) begin
						mean_q[ri] <= nm_sat;
					end
				end
				OP_COUNT: begin
					if (cmd.rem) begin
						count_q <= count_q - 32'd1;
					end else if (count_q != 32'hFFFF_FFFF) begin
						count_q <= count_q + 32'd1;
					end
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_EMIT_MEAN || cmd.op == OP_EMIT_COV) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// operand buffers, coefficients, products and output payload
	always_ff @(posedge clk) begin
		if (cmd.buf_wr && (int'(component) < MAX_DIMS)) begin
			point_q[component[RW-1:0]] <= value;
			var_q[component[RW-1:0]]   <= variance;
		end
		if (cmd.op == OP_DIV_START) begin
			dvd_q <= dvd_n;
			rem_q <= 33'd0;
			quo_q <= 64'd0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= rem_n[32:0];
			quo_q <= {quo_q[62:0], rem_ge};
		end
		if (cmd.op == OP_SETUP) begin
			den_q  <= den_n;
			half_q <= den_n[32:1];
		end
		if (cmd.op == OP_DIV_TAKE) begin
			case (cmd.dsel)
				DS_P1:   p1_q <= quo_q[33:0];
				DS_P2:   p2_q <= quo_q[33:0];
				DS_QV:   qv_q <= quo_q[32:0];
				default: begin
				end
			endcase
		end
		if (cmd.op == OP_DIFF) begin
			for (int i = 0; i < MAX_DIMS; i++) begin
				d_q[i] <= {point_q[i][31], point_q[i]} - {mean_q[i][31], mean_q[i]};
			end
		end
		if (cmd.op == OP_COV_RD) begin
			rvld_q <= vld_q[cidx];
		end
		// 32x32 multiplier, then shifted accumulate
		pp_s1    <= 64'(a_part) * 64'(b_part);
		step_s1  <= cmd.step;
		first_s1 <= (cmd.step == 2'd0);
		if (mv_s1) begin
			acc_q <= (first_s1 ? '0 : acc_q) + pp_sh;
		end
		if (cmd.op == OP_FIN) begin
			case (cmd.msel)
				MS_DD:   prod_q <= acc_q[63:0];
				MS_CV:   t_q    <= sc;
				default: t_q    <= sat_add(t_q, sc);
			endcase
		end
		if (cmd.op == OP_EMIT_MEAN) begin
			kind         <= 1'b0;
			row          <= cmd.row;
			col          <= 3'd0;
			result_value <= 64'(mean_q[ri]);
			sample_count <= count_q;
			last         <= 1'b0;
		end else if (cmd.op == OP_EMIT_COV) begin
			kind         <= 1'b1;
			row          <= cmd.row;
			col          <= cmd.col;
			result_value <= cv;
			sample_count <= count_q;
			last         <= cmd.last;
		end
	end
endmodule

/* rtl/ommc_chk.sv */
`timescale 1ns / 1ps
module ommc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        kind,
	input logic [2:0]  row,
	input logic [2:0]  col,
	input logic [63:0] result_value,
	input logic        last
);
	// a held beat keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(last))
		else $error("output beat changed while stalled");

	// no new input while a run is still being emitted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken during result run");

	// covariance beats stay in the upper triangle
	a_tri: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> row <= col)
		else $error("covariance beat below diagonal");

	// mean beats carry column zero
	a_mcol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> col == 3'd0)
		else $error("mean beat with nonzero column");
endmodule

bind online_mean_covariance_unit ommc_chk u_chk (.*);
